/* rtl/core/fbrb_pkg.sv */
// fbrb_pkg: shared types and constants of the framebuffer register block
// register offsets, interrupt bits, action codes and result layout
// no dependencies
`default_nettype none

package fbrb_pkg;

   // transaction kinds carried in req_tuser
   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_VSYNC = 2'd2,
      ACT_PIXEL = 2'd3
   } action_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_HEIGHT = 2'd1;

   // register window byte offsets, compared at 16 bits
   localparam logic [15:0] OFS_WIDTH    = 16'h0000;
   localparam logic [15:0] OFS_HEIGHT   = 16'h0004;
   localparam logic [15:0] OFS_STATUS   = 16'h0008;
   localparam logic [15:0] OFS_ENABLE   = 16'h000c;
   localparam logic [15:0] OFS_BASE     = 16'h0010;
   localparam logic [15:0] OFS_ROTATION = 16'h0014;
   localparam logic [15:0] OFS_BLANK    = 16'h0018;
   localparam logic [15:0] OFS_PWIDTH   = 16'h001c;
   localparam logic [15:0] OFS_PHEIGHT  = 16'h0020;

   // interrupt status bits
   localparam logic [1:0] IRQ_VSYNC     = 2'b01;
   localparam logic [1:0] IRQ_BASE_DONE = 2'b10;

   // frame geometry and color constants
   localparam int DIM_W = 12;
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd320;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   // result layout
   localparam int RSP_FIELD_W = 32 + 1 + 1 + 32 + 32;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   // frame state the pixel path needs
   typedef struct packed {
      logic [31:0]      base;
      logic [DIM_W-1:0] width;
      logic             blanked;
   } frame_cfg_type;

endpackage

`default_nettype wire

/* rtl/core/fbrb_regs.sv */
// fbrb_regs: register file of the framebuffer block, interrupt status and enable
// decodes read, write and vsync transactions; depends on fbrb_pkg
`default_nettype none

module fbrb_regs #(
   parameter int REG_SPACE_BITS = 12
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   input  wire logic [fbrb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [31:0]                           csr_data,
   input  wire logic                                  exec_valid,
   input  wire fbrb_pkg::action_type                  action,
   input  wire logic [REG_SPACE_BITS-1:0]             reg_offset,
   input  wire logic [31:0]                           write_data,
   output logic [31:0]                                read_data,
   output logic                                       irq,
   output logic                                       render_request,
   output fbrb_pkg::frame_cfg_type                    frame
);
   import fbrb_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [1:0]       pending_ff, pending_in;
   logic [31:0]      mask_ff, mask_in;
   logic [31:0]      base_ff, base_in;
   logic             blanked_ff, blanked_in;
   logic [15:0]      ofs;

   assign ofs = 16'(reg_offset);

   // configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DISPLAY_WIDTH:  width_in  = csr_data[DIM_W-1:0];
            CSR_DISPLAY_HEIGHT: height_in = csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // transaction decode and next state
   always_comb begin
      pending_in     = pending_ff;
      mask_in        = mask_ff;
      base_in        = base_ff;
      blanked_in     = blanked_ff;
      read_data      = '0;
      render_request = 1'b0;
      case (action)
         ACT_READ: begin
            case (ofs)
               OFS_WIDTH, OFS_PWIDTH:   read_data = 32'(width_ff);
               OFS_HEIGHT, OFS_PHEIGHT: read_data = 32'(height_ff);
               OFS_STATUS: begin
                  read_data  = 32'(pending_ff);
                  pending_in = '0;
               end
               OFS_ENABLE:              read_data = mask_ff;
               default:                 read_data = '0;
            endcase
         end
         ACT_WRITE: begin
            case (ofs)
               OFS_ENABLE: mask_in = write_data;
               OFS_BASE: begin
                  base_in        = write_data;
                  pending_in     = pending_ff | IRQ_BASE_DONE;
                  render_request = 1'b1;
               end
               OFS_ROTATION: render_request = 1'b1;
               OFS_BLANK: begin
                  blanked_in     = (write_data != 32'd0);
                  render_request = 1'b1;
               end
               default: ;
            endcase
         end
         ACT_VSYNC: begin
            if ((mask_ff[1:0] & IRQ_VSYNC) != 2'b00) begin
               pending_in = pending_ff | IRQ_VSYNC;
            end
         end
         default: ;
      endcase
   end

   // interrupt line as seen after this transaction
   assign irq = (pending_in & mask_in[1:0]) != 2'b00;

   assign frame.base    = base_ff;
   assign frame.width   = width_ff;
   assign frame.blanked = blanked_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         pending_ff <= '0;
         mask_ff    <= '0;
         base_ff    <= '0;
         blanked_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         if (exec_valid) begin
            pending_ff <= pending_in;
            mask_ff    <= mask_in;
            base_ff    <= base_in;
            blanked_ff <= blanked_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fbrb_pixel.sv */
// fbrb_pixel: pixel address generation and rgb565 to argb8888 widening
// combinational; depends on fbrb_pkg for the frame state struct
`default_nettype none

module fbrb_pixel #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                     is_pixel,
   input  wire fbrb_pkg::frame_cfg_type  frame,
   input  wire logic [COORD_BITS-1:0]    pixel_x,
   input  wire logic [COORD_BITS-1:0]    pixel_y,
   input  wire logic [15:0]              pixel_in,
   output logic [31:0]                   pixel_address,
   output logic [31:0]                   pixel_out
);
   import fbrb_pkg::*;

   localparam int PROD_W = COORD_BITS + DIM_W;

   logic [PROD_W-1:0] row_offset;
   logic [PROD_W:0]   linear;
   logic [7:0]        red, green, blue;

   // linear pixel index, then byte address
   assign row_offset = PROD_W'(pixel_y) * PROD_W'(frame.width);
   assign linear     = (PROD_W+1)'(row_offset) + (PROD_W+1)'(pixel_x);

   // replicate high bits into the low bits of each channel
   assign red   = {pixel_in[15:11], pixel_in[15:13]};
   assign green = {pixel_in[10:5], pixel_in[10:9]};
   assign blue  = {pixel_in[4:0], pixel_in[4:2]};

   always_comb begin
      pixel_address = '0;
      pixel_out     = '0;
      if (is_pixel) begin
         pixel_address = frame.base + 32'({linear, 1'b0});
         if (!frame.blanked) begin
            pixel_out = {ALPHA_OPAQUE, red, green, blue};
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/framebuffer_register_block.sv */
// framebuffer_register_block: top level with input register, execute logic, result register
// uses fbrb_pkg, fbrb_regs and fbrb_pixel
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  req     | in        | req_tvalid/req_tready  | tuser action, tdata offset/data/x/y/pixel
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata read/irq/render/address/pixel
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data (always ready)
//
// one transaction per cycle sustained while rsp is not stalled; a request passes
// the input register, then decode, state update and pixel math into the result register
// the execute step runs whenever an item waits and the result register is empty or being drained
// a stalled rsp holds the result and the input register; req_tready then drops once the input register is full
// reset clears the valid flags and the register file state; width and height return to 320 and 480
`default_nettype none

module framebuffer_register_block #(
   parameter int REG_SPACE_BITS = 12,
   parameter int COORD_BITS     = 12
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // slave side
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // tdata: reg_offset, write_data, pixel_x, pixel_y, pixel_in (lsb first), zero padded
   input  wire logic [((REG_SPACE_BITS+2*COORD_BITS+48+7)/8)*8-1:0] req_tdata,
   // tuser: action
   input  wire logic [1:0]                               req_tuser,
   // master side
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // tdata: read_data, irq, render_request, pixel_address, pixel_out (lsb first)
   output logic [fbrb_pkg::RSP_DATA_W-1:0]               rsp_tdata,
   // configuration
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [fbrb_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [31:0]                              csr_data
);
   import fbrb_pkg::*;

   localparam int X_LSB   = REG_SPACE_BITS + 32;
   localparam int Y_LSB   = X_LSB + COORD_BITS;
   localparam int PIX_LSB = Y_LSB + COORD_BITS;

   // input register
   logic                      in_valid_ff, in_valid_in;
   action_type                action_ff;
   logic [REG_SPACE_BITS-1:0] offset_ff;
   logic [31:0]               wdata_ff;
   logic [COORD_BITS-1:0]     x_ff, y_ff;
   logic [15:0]               pin_ff;

   // result register
   logic                      out_valid_ff, out_valid_in;
   logic [31:0]               rd_ff, addr_ff, pix_ff;
   logic                      irq_ff, render_ff;

   logic                      exec;
   logic [31:0]               rd_c, addr_c, pix_c;
   logic                      irq_c, render_c;
   frame_cfg_type             frame;

   // execute when an item waits and the result register can take it
   assign exec       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || exec;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !exec);
   assign out_valid_in = exec || (out_valid_ff && !rsp_tready);

   fbrb_regs #(
      .REG_SPACE_BITS (REG_SPACE_BITS)
   ) u_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .exec_valid     (exec),
      .action         (action_ff),
      .reg_offset     (offset_ff),
      .write_data     (wdata_ff),
      .read_data      (rd_c),
      .irq            (irq_c),
      .render_request (render_c),
      .frame          (frame)
   );

   fbrb_pixel #(
      .COORD_BITS (COORD_BITS)
   ) u_pixel (
      .is_pixel      (action_ff == ACT_PIXEL),
      .frame         (frame),
      .pixel_x       (x_ff),
      .pixel_y       (y_ff),
      .pixel_in      (pin_ff),
      .pixel_address (addr_c),
      .pixel_out     (pix_c)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input payload capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         action_ff <= action_type'(req_tuser);
         offset_ff <= req_tdata[REG_SPACE_BITS-1:0];
         wdata_ff  <= req_tdata[X_LSB-1:REG_SPACE_BITS];
         x_ff      <= req_tdata[Y_LSB-1:X_LSB];
         y_ff      <= req_tdata[PIX_LSB-1:Y_LSB];
         pin_ff    <= req_tdata[PIX_LSB+15:PIX_LSB];
      end
   end

   // result payload capture
   always_ff @(posedge clock) begin
      if (exec) begin
         rd_ff     <= rd_c;
         irq_ff    <= irq_c;
         render_ff <= render_c;
         addr_ff   <= addr_c;
         pix_ff    <= pix_c;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, pix_ff, addr_ff, render_ff, irq_ff, rd_ff};

   // a redraw request comes from a write, which never carries pixel data
   a_render_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && render_ff) |-> (pix_ff == 32'd0 && addr_ff == 32'd0 && rd_ff == 32'd0))
      else $error("render request together with pixel or read data");

   // read data and pixel address come from different actions
   a_read_vs_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rd_ff == 32'd0 || (addr_ff == 32'd0 && pix_ff == 32'd0)))
      else $error("read data and pixel result in one transaction");

   // with the result register empty the block always takes a new item
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

`default_nettype wire
